// ===== rtl/ppe_pkg.sv =====
// ppe_pkg: shared types, codes and constants of the projectile pool engine
// no dependencies; used by every file under rtl
package ppe_pkg;

  localparam int PLAYER_SLOTS = 16;
  localparam int ENEMY_SLOTS  = 32;
  localparam int POOL_CAP     = 64;

  localparam int SLOT_W = 6;
  localparam int CNT_W  = $clog2(POOL_CAP + 1);
  localparam int PIDX_W = (PLAYER_SLOTS > 1) ? $clog2(PLAYER_SLOTS) : 1;
  localparam int EIDX_W = (ENEMY_SLOTS > 1) ? $clog2(ENEMY_SLOTS) : 1;

  localparam int SCREEN_W    = 240;
  localparam int SCREEN_H    = 320;
  localparam int EDGE_MARGIN = 10;

  localparam logic signed [15:0] X_LO = 16'(-EDGE_MARGIN);
  localparam logic signed [15:0] X_HI = 16'(SCREEN_W + EDGE_MARGIN);
  localparam logic signed [15:0] Y_LO = 16'(-EDGE_MARGIN);
  localparam logic signed [15:0] Y_HI = 16'(SCREEN_H + EDGE_MARGIN);

  localparam logic [1:0] CMD_SPAWN   = 2'd0;
  localparam logic [1:0] CMD_DESTROY = 2'd1;
  localparam logic [1:0] CMD_TICK    = 2'd2;
  localparam logic [1:0] CMD_READ    = 2'd3;

  localparam logic [1:0] TYPE_PLAYER  = 2'd0;
  localparam logic [1:0] TYPE_ENEMY   = 2'd1;
  localparam logic [1:0] TYPE_MISSILE = 2'd2;
  localparam logic [1:0] TYPE_INVALID = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_BAD_TYPE = 3'd2;
  localparam logic [2:0] ST_INACTIVE = 3'd3;
  localparam logic [2:0] ST_BEYOND   = 3'd4;

  typedef struct packed {
    logic [1:0]        command;
    logic              is_player;
    logic [1:0]        object_type;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic [SLOT_W-1:0] slot;
  } item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [SLOT_W-1:0]  slot_out;
    logic               active;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [1:0]         damage;
    logic [CNT_W-1:0]   player_count;
    logic [CNT_W-1:0]   enemy_count;
  } result_t;

  // which kind of result the datapath forms at the end of an item
  typedef enum logic [2:0] {
    FIN_NONE,
    FIN_BAD_TYPE,
    FIN_FULL,
    FIN_SPAWN,
    FIN_DESTROY,
    FIN_READ,
    FIN_TICK
  } fin_t;

  typedef struct packed {
    logic load;
    logic scan_clr;
    logic scan_inc;
    logic rd_en;
    logic tick_issue;
    logic tick_player;
    fin_t fin;
  } ctl_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       bad_type;
    logic       scan_end;
    logic       scan_live;
    logic       p_last;
    logic       e_last;
  } sts_t;

  function automatic logic [1:0] damage_of(input logic [1:0] kind);
    logic [1:0] d;
    case (kind)
      TYPE_PLAYER:  d = 2'd1;
      TYPE_ENEMY:   d = 2'd1;
      TYPE_MISSILE: d = 2'd2;
      default:      d = 2'd0;
    endcase
    return d;
  endfunction

endpackage

// ===== rtl/ppe_ctrl.sv =====
// ppe_ctrl: sequencer of the projectile pool engine
// depends on ppe_pkg; drives ppe_datapath through ctl_t, reads sts_t
module ppe_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  ppe_pkg::sts_t sts,
  output ppe_pkg::ctl_t ctl,
  output logic          busy,
  output logic          done
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_FIND,
    S_READ,
    S_TICK_P,
    S_TICK_E,
    S_DRAIN
  } state_t;

  state_t state, state_next;
  logic   busy_next, done_next;

  always_comb begin
    ctl        = '0;
    ctl.fin    = ppe_pkg::FIN_NONE;
    state_next = state;
    busy_next  = busy;
    done_next  = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          ctl.load   = 1'b1;
          busy_next  = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts.cmd)
          ppe_pkg::CMD_SPAWN: begin
            if (sts.bad_type) begin
              ctl.fin = ppe_pkg::FIN_BAD_TYPE;
            end else begin
              ctl.scan_clr = 1'b1;
              state_next   = S_FIND;
            end
          end
          ppe_pkg::CMD_DESTROY: begin
            ctl.fin = ppe_pkg::FIN_DESTROY;
          end
          ppe_pkg::CMD_TICK: begin
            ctl.scan_clr = 1'b1;
            state_next   = S_TICK_P;
          end
          default: begin
            ctl.rd_en  = 1'b1;
            state_next = S_READ;
          end
        endcase
      end
      S_FIND: begin
        if (sts.scan_end) begin
          ctl.fin = ppe_pkg::FIN_FULL;
        end else if (!sts.scan_live) begin
          ctl.fin = ppe_pkg::FIN_SPAWN;
        end else begin
          ctl.scan_inc = 1'b1;
        end
      end
      S_READ: begin
        ctl.fin = ppe_pkg::FIN_READ;
      end
      S_TICK_P: begin
        ctl.tick_issue  = 1'b1;
        ctl.tick_player = 1'b1;
        if (sts.p_last) begin
          ctl.scan_clr = 1'b1;
          state_next   = S_TICK_E;
        end else begin
          ctl.scan_inc = 1'b1;
        end
      end
      S_TICK_E: begin
        ctl.tick_issue = 1'b1;
        if (sts.e_last) begin
          state_next = S_DRAIN;
        end else begin
          ctl.scan_inc = 1'b1;
        end
      end
      S_DRAIN: begin
        // last slot update lands on this edge, counts come from next values
        ctl.fin = ppe_pkg::FIN_TICK;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (ctl.fin != ppe_pkg::FIN_NONE) begin
      state_next = S_IDLE;
      busy_next  = 1'b0;
      done_next  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= busy_next;
      done  <= done_next;
    end
  end

endmodule

// ===== rtl/ppe_datapath.sv =====
// ppe_datapath: slot flags, position and velocity memories, live counters,
// motion update and result register; depends on ppe_pkg, driven by ppe_ctrl
module ppe_datapath (
  input  logic             clk,
  input  logic             rst,
  input  ppe_pkg::item_t   item_in,
  input  ppe_pkg::ctl_t    ctl,
  output ppe_pkg::sts_t    sts,
  output ppe_pkg::result_t result
);

  localparam int PS = ppe_pkg::PLAYER_SLOTS;
  localparam int ES = ppe_pkg::ENEMY_SLOTS;
  localparam int PW = ppe_pkg::PIDX_W;
  localparam int EW = ppe_pkg::EIDX_W;
  localparam int CW = ppe_pkg::CNT_W;
  localparam int SW = ppe_pkg::SLOT_W;

  ppe_pkg::item_t item;
  logic [CW-1:0]  scan;

  // per-slot flags; wr marks a position that has been written
  logic       p_live [PS];
  logic [1:0] p_kind [PS];
  logic       p_wr   [PS];
  logic       e_live [ES];
  logic [1:0] e_kind [ES];
  logic       e_wr   [ES];

  logic [31:0] p_pos [PS];
  logic [31:0] p_vel [PS];
  logic [31:0] e_pos [ES];
  logic [31:0] e_vel [ES];
  logic [31:0] p_pos_q, p_vel_q, e_pos_q, e_vel_q;

  logic [CW-1:0] p_cnt, p_cnt_next, e_cnt, e_cnt_next;

  logic          upd_valid, upd_player;
  logic [SW-1:0] upd_idx;

  logic p_slot_ok, e_slot_ok, slot_ok, slot_live, slot_wr;
  logic [1:0] slot_kind;
  logic [PW-1:0] p_sidx, p_scan, p_uidx, p_raddr, p_waddr;
  logic [EW-1:0] e_sidx, e_scan, e_uidx, e_raddr, e_waddr;

  logic spawn_go, destroy_go, upd_live, upd_kill, off;
  logic p_re, e_re, p_we, e_we, p_set, e_set, p_clr, e_clr;
  logic [31:0] wdata, cur_pos, cur_vel;
  logic signed [15:0] cur_x, cur_y, cur_vx, cur_vy, nx, ny;
  ppe_pkg::result_t res_next;

  assign p_sidx = item.slot[PW-1:0];
  assign e_sidx = item.slot[EW-1:0];
  assign p_scan = scan[PW-1:0];
  assign e_scan = scan[EW-1:0];
  assign p_uidx = upd_idx[PW-1:0];
  assign e_uidx = upd_idx[EW-1:0];

  always_comb begin
    p_slot_ok = {1'b0, item.slot} < CW'(PS);
    e_slot_ok = {1'b0, item.slot} < CW'(ES);
    if (item.is_player) begin
      slot_ok   = p_slot_ok;
      slot_live = p_slot_ok && p_live[p_sidx];
      slot_wr   = p_slot_ok && p_wr[p_sidx];
      slot_kind = p_slot_ok ? p_kind[p_sidx] : 2'd0;
    end else begin
      slot_ok   = e_slot_ok;
      slot_live = e_slot_ok && e_live[e_sidx];
      slot_wr   = e_slot_ok && e_wr[e_sidx];
      slot_kind = e_slot_ok ? e_kind[e_sidx] : 2'd0;
    end
  end

  always_comb begin
    sts.cmd      = item.command;
    sts.bad_type = item.object_type == ppe_pkg::TYPE_INVALID;
    sts.scan_end = item.is_player ? (scan >= CW'(PS)) : (scan >= CW'(ES));
    sts.scan_live = !sts.scan_end &&
                    (item.is_player ? p_live[p_scan] : e_live[e_scan]);
    sts.p_last   = scan == CW'(PS - 1);
    sts.e_last   = scan == CW'(ES - 1);
  end

  // motion update of the slot read in the previous cycle
  always_comb begin
    cur_pos = upd_player ? p_pos_q : e_pos_q;
    cur_vel = upd_player ? p_vel_q : e_vel_q;
    cur_x   = cur_pos[31:16];
    cur_y   = cur_pos[15:0];
    cur_vx  = cur_vel[31:16];
    cur_vy  = cur_vel[15:0];
    nx      = cur_x + cur_vx;
    ny      = upd_player ? (cur_y + cur_vy) : (cur_y - cur_vy);
    off     = (nx < ppe_pkg::X_LO) || (nx > ppe_pkg::X_HI) ||
              (ny < ppe_pkg::Y_LO) || (ny > ppe_pkg::Y_HI);
    upd_live = upd_valid && (upd_player ? p_live[p_uidx] : e_live[e_uidx]);
    upd_kill = upd_live && off;
  end

  always_comb begin
    spawn_go   = ctl.fin == ppe_pkg::FIN_SPAWN;
    destroy_go = (ctl.fin == ppe_pkg::FIN_DESTROY) && slot_live;
    p_set = spawn_go && item.is_player;
    e_set = spawn_go && !item.is_player;
    p_clr = (destroy_go && item.is_player) || (upd_kill && upd_player);
    e_clr = (destroy_go && !item.is_player) || (upd_kill && !upd_player);
    p_we  = p_set || (upd_live && upd_player);
    e_we  = e_set || (upd_live && !upd_player);
    p_waddr = spawn_go ? p_scan : p_uidx;
    e_waddr = spawn_go ? e_scan : e_uidx;
    wdata = spawn_go ? {item.start_x, item.start_y} : {nx, ny};
    p_re = (ctl.rd_en && item.is_player && p_slot_ok) || (ctl.tick_issue && ctl.tick_player);
    e_re = (ctl.rd_en && !item.is_player && e_slot_ok) || (ctl.tick_issue && !ctl.tick_player);
    p_raddr = ctl.tick_issue ? p_scan : p_sidx;
    e_raddr = ctl.tick_issue ? e_scan : e_sidx;
  end

  always_comb begin
    p_cnt_next = p_cnt;
    if (p_set && p_cnt != {CW{1'b1}}) begin
      p_cnt_next = p_cnt + CW'(1);
    end else if (p_clr && p_cnt != '0) begin
      p_cnt_next = p_cnt - CW'(1);
    end
    e_cnt_next = e_cnt;
    if (e_set && e_cnt != {CW{1'b1}}) begin
      e_cnt_next = e_cnt + CW'(1);
    end else if (e_clr && e_cnt != '0) begin
      e_cnt_next = e_cnt - CW'(1);
    end
  end

  always_comb begin
    res_next = '0;
    res_next.player_count = p_cnt_next;
    res_next.enemy_count  = e_cnt_next;
    case (ctl.fin)
      ppe_pkg::FIN_BAD_TYPE: res_next.status = ppe_pkg::ST_BAD_TYPE;
      ppe_pkg::FIN_FULL:     res_next.status = ppe_pkg::ST_FULL;
      ppe_pkg::FIN_SPAWN: begin
        res_next.status   = ppe_pkg::ST_OK;
        res_next.slot_out = scan[SW-1:0];
        res_next.active   = 1'b1;
        res_next.pos_x    = item.start_x;
        res_next.pos_y    = item.start_y;
        res_next.damage   = ppe_pkg::damage_of(item.object_type);
      end
      ppe_pkg::FIN_DESTROY: begin
        res_next.slot_out = item.slot;
        if (!slot_ok) begin
          res_next.status = ppe_pkg::ST_BEYOND;
        end else if (!slot_live) begin
          res_next.status = ppe_pkg::ST_INACTIVE;
        end else begin
          res_next.status = ppe_pkg::ST_OK;
        end
      end
      ppe_pkg::FIN_READ: begin
        res_next.slot_out = item.slot;
        if (!slot_ok) begin
          res_next.status = ppe_pkg::ST_BEYOND;
        end else begin
          res_next.status = slot_live ? ppe_pkg::ST_OK : ppe_pkg::ST_INACTIVE;
          res_next.active = slot_live;
          if (slot_wr) begin
            {res_next.pos_x, res_next.pos_y} = item.is_player ? p_pos_q : e_pos_q;
          end
          res_next.damage = ppe_pkg::damage_of(slot_kind);
        end
      end
      default: res_next.status = ppe_pkg::ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      item <= item_in;
    end
    if (ctl.fin != ppe_pkg::FIN_NONE) begin
      result <= res_next;
    end
    upd_player <= ctl.tick_player;
    upd_idx    <= scan[SW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan      <= '0;
      upd_valid <= 1'b0;
      p_cnt     <= '0;
      e_cnt     <= '0;
    end else begin
      if (ctl.scan_clr) begin
        scan <= '0;
      end else if (ctl.scan_inc) begin
        scan <= scan + CW'(1);
      end
      upd_valid <= ctl.tick_issue;
      p_cnt     <= p_cnt_next;
      e_cnt     <= e_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PS; i++) begin
        p_live[i] <= 1'b0;
        p_kind[i] <= 2'd0;
        p_wr[i]   <= 1'b0;
      end
    end else if (p_set) begin
      p_live[p_scan] <= 1'b1;
      p_kind[p_scan] <= item.object_type;
      p_wr[p_scan]   <= 1'b1;
    end else if (p_clr) begin
      p_live[upd_kill ? p_uidx : p_sidx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ES; i++) begin
        e_live[i] <= 1'b0;
        e_kind[i] <= 2'd0;
        e_wr[i]   <= 1'b0;
      end
    end else if (e_set) begin
      e_live[e_scan] <= 1'b1;
      e_kind[e_scan] <= item.object_type;
      e_wr[e_scan]   <= 1'b1;
    end else if (e_clr) begin
      e_live[upd_kill ? e_uidx : e_sidx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p_we) begin
      p_pos[p_waddr] <= wdata;
    end
    if (p_set) begin
      p_vel[p_scan] <= {item.vel_x, item.vel_y};
    end
    if (p_re) begin
      p_pos_q <= p_pos[p_raddr];
      p_vel_q <= p_vel[p_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (e_we) begin
      e_pos[e_waddr] <= wdata;
    end
    if (e_set) begin
      e_vel[e_scan] <= {item.vel_x, item.vel_y};
    end
    if (e_re) begin
      e_pos_q <= e_pos[e_raddr];
      e_vel_q <= e_vel[e_raddr];
    end
  end

endmodule

// ===== rtl/projectile_pool_engine_top.sv =====
// projectile_pool_engine_top: two object pools with spawn, destroy, tick, read
// depends on ppe_pkg, ppe_ctrl, ppe_datapath
//
//   channel   ports                 handshake
//   command   start, busy, item     word taken when start && !busy
//   result    done, result          word valid for the one cycle done is high
//
// one result word per command; spawn searches for the lowest free slot and tick
// steps through all player slots, then all enemy slots, one slot a cycle.
// a new command may be accepted in the cycle done is high.
// synchronous reset clears all slot flags and counters, no clearing pass.
// results cannot be stalled by the receiver.
module projectile_pool_engine_top (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  ppe_pkg::item_t   item,
  output logic             busy,
  output logic             done,
  output ppe_pkg::result_t result
);

  ppe_pkg::ctl_t ctl;
  ppe_pkg::sts_t sts;

  ppe_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .ctl   (ctl),
    .busy  (busy),
    .done  (done)
  );

  ppe_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .item_in (item),
    .ctl     (ctl),
    .sts     (sts),
    .result  (result)
  );

endmodule

// ===== rtl/ppe_checker.sv =====
// ppe_checker: port-level assertions on the projectile pool engine
// depends on ppe_pkg; bound to projectile_pool_engine_top below
module ppe_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input ppe_pkg::result_t result
);

  // a result word lasts exactly one cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("busy still high with the result word");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.player_count <= ppe_pkg::CNT_W'(ppe_pkg::PLAYER_SLOTS)) &&
             (result.enemy_count <= ppe_pkg::CNT_W'(ppe_pkg::ENEMY_SLOTS)))
    else $error("live count beyond pool size");

  // a live object always carries a valid type
  a_live_damage: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == ppe_pkg::ST_OK && result.active) |->
    result.damage != 2'd0)
    else $error("live object reported with zero damage");

endmodule

bind projectile_pool_engine_top ppe_checker u_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

// ===== bench/tb_top.sv =====
// tb_top: self-checking bench for projectile_pool_engine_top
// depends on ppe_pkg and the rtl; scores each result word against a behavioral pool model
`timescale 1ns / 1ps

module tb_top;
  import ppe_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_WORDS = 1250;
  localparam int DRAIN_CYCLES = PLAYER_SLOTS + ENEMY_SLOTS + 12;

  // damage per object kind, two bits each, kind 0 in the low bits
  localparam logic [7:0] DAMAGE_BY_KIND = {2'd0, 2'd2, 2'd1, 2'd1};

  typedef struct packed {
    logic               live;
    logic [1:0]         kind;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
  } slot_state_t;

  logic    clk   = 1'b0;
  logic    rst   = 1'b1;
  logic    start = 1'b0;
  item_t   item  = '0;
  logic    busy;
  logic    done;
  result_t result;

  projectile_pool_engine_top u_top (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // pool model, index 1 player, index 0 enemy
  slot_state_t      pools [2][POOL_CAP];
  logic [CNT_W-1:0] live_cnt [2];

  item_t   cmd_backlog [$];
  result_t pending_replies [$];
  int      total_words = 0;
  int      taken_cnt   = 0;
  int      bad_words   = 0;
  int      cycles      = 0;
  int      gap_left    = 0;
  int      calm_left   = 0;
  logic    taken       = 1'b0;
  result_t want;
  result_t pred;

  function automatic int pool_size(logic p);
    return p ? PLAYER_SLOTS : ENEMY_SLOTS;
  endfunction

  function automatic logic off_field(logic signed [15:0] x, logic signed [15:0] y);
    return (x < X_LO) || (x > X_HI) || (y < Y_LO) || (y > Y_HI);
  endfunction

  task automatic pool_step(input item_t w, output result_t r);
    int p;
    int sz;
    int k;
    int i;
    int q;
    r = '0;
    p = w.is_player ? 1 : 0;
    sz = pool_size(w.is_player);
    case (w.command)
      CMD_SPAWN: begin
        if (w.object_type == TYPE_INVALID) begin
          r.status = ST_BAD_TYPE;
        end else begin
          k = sz;
          for (i = sz - 1; i >= 0; i--)
            if (!pools[p][i].live) k = i;
          if (k == sz) begin
            r.status = ST_FULL;
          end else begin
            pools[p][k].live = 1'b1;
            pools[p][k].kind = w.object_type;
            pools[p][k].px   = w.start_x;
            pools[p][k].py   = w.start_y;
            pools[p][k].vx   = w.vel_x;
            pools[p][k].vy   = w.vel_y;
            if (live_cnt[p] != '1) live_cnt[p] = live_cnt[p] + CNT_W'(1);
            r.status   = ST_OK;
            r.slot_out = SLOT_W'(k);
            r.active   = 1'b1;
            r.pos_x    = w.start_x;
            r.pos_y    = w.start_y;
            r.damage   = DAMAGE_BY_KIND[{w.object_type, 1'b0} +: 2];
          end
        end
      end
      CMD_DESTROY: begin
        r.slot_out = w.slot;
        if (int'(w.slot) >= sz) begin
          r.status = ST_BEYOND;
        end else if (!pools[p][w.slot].live) begin
          r.status = ST_INACTIVE;
        end else begin
          r.status = ST_OK;
          pools[p][w.slot].live = 1'b0;
          if (live_cnt[p] != '0) live_cnt[p] = live_cnt[p] - CNT_W'(1);
        end
      end
      CMD_TICK: begin
        r.status = ST_OK;
        for (q = 0; q < 2; q++) begin
          for (i = 0; i < pool_size(q[0]); i++) begin
            if (pools[q][i].live) begin
              pools[q][i].px = pools[q][i].px + pools[q][i].vx;
              // enemy objects fall, so their y step is subtracted
              if (q == 1) pools[q][i].py = pools[q][i].py + pools[q][i].vy;
              else pools[q][i].py = pools[q][i].py - pools[q][i].vy;
              if (off_field(pools[q][i].px, pools[q][i].py)) begin
                pools[q][i].live = 1'b0;
                if (live_cnt[q] != '0) live_cnt[q] = live_cnt[q] - CNT_W'(1);
              end
            end
          end
        end
      end
      default: begin
        r.slot_out = w.slot;
        if (int'(w.slot) >= sz) begin
          r.status = ST_BEYOND;
        end else begin
          // an inactive slot still reports what it last held
          r.status = pools[p][w.slot].live ? ST_OK : ST_INACTIVE;
          r.active = pools[p][w.slot].live;
          r.pos_x  = pools[p][w.slot].px;
          r.pos_y  = pools[p][w.slot].py;
          r.damage = DAMAGE_BY_KIND[{pools[p][w.slot].kind, 1'b0} +: 2];
        end
      end
    endcase
    r.player_count = live_cnt[1];
    r.enemy_count  = live_cnt[0];
  endtask

  function automatic item_t mk(logic [1:0] cmd, logic p, logic [1:0] typ,
                               int x, int y, int vx, int vy, int s);
    item_t w;
    w.command     = cmd;
    w.is_player   = p;
    w.object_type = typ;
    w.start_x     = 16'(x);
    w.start_y     = 16'(y);
    w.vel_x       = 16'(vx);
    w.vel_y       = 16'(vy);
    w.slot        = SLOT_W'(s);
    return w;
  endfunction

  function automatic int any16();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  function automatic item_t spawn_word(logic p, logic wild);
    logic [1:0] typ;
    int x;
    int y;
    int vx;
    int vy;
    typ = 2'($urandom_range(0, 2));
    x  = int'($urandom_range(0, 260)) - 10;
    y  = int'($urandom_range(0, 340)) - 10;
    vx = int'($urandom_range(0, 8)) - 4;
    vy = int'($urandom_range(0, 8)) - 4;
    if ($urandom_range(0, 7) == 0) x = $urandom_range(0, 1) ? -10 : 250;
    if ($urandom_range(0, 7) == 0) y = $urandom_range(0, 1) ? -10 : 330;
    if ($urandom_range(0, 9) == 0) vx = int'($urandom_range(0, 80)) - 40;
    if ($urandom_range(0, 9) == 0) vy = int'($urandom_range(0, 80)) - 40;
    if (wild) begin
      typ = 2'($urandom_range(0, 3));
      x  = any16();
      y  = any16();
      vx = any16();
      vy = any16();
    end
    return mk(CMD_SPAWN, p, typ, x, y, vx, vy, int'($urandom_range(0, 63)));
  endfunction

  function automatic item_t slot_word(logic [1:0] cmd, logic p, logic anywhere);
    int s;
    s = anywhere ? int'($urandom_range(0, 63)) : int'($urandom_range(0, pool_size(p) - 1));
    return mk(cmd, p, 2'($urandom_range(0, 3)), any16(), any16(), any16(), any16(), s);
  endfunction

  task automatic queue_word(input item_t w);
    cmd_backlog.push_back(w);
  endtask

  function automatic int next_gap();
    int r;
    if (calm_left != 0) begin
      calm_left--;
      return 0;
    end
    r = int'($urandom_range(0, 199));
    if (r < 2) begin
      calm_left = int'($urandom_range(30, 120));
      return 0;
    end
    if (r < 110) return 0;
    if (r < 170) return int'($urandom_range(1, 3));
    if (r < 194) return int'($urandom_range(4, 20));
    return int'($urandom_range(30, 90));
  endfunction

  // command driver, words change on the falling edge
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || taken) begin
      if (gap_left != 0) begin
        start    <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (cmd_backlog.size() != 0) begin
        item     <= cmd_backlog.pop_front();
        start    <= 1'b1;
        gap_left <= next_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // result monitor and model update on the rising edge
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst) begin
      taken <= 1'b0;
    end else begin
      taken <= start && !busy;
      if (done) begin
        if (pending_replies.size() == 0) begin
          bad_words++;
          if (bad_words <= 10) begin
            $display("result word with nothing pending, cycle %0d", cycles);
          end
        end else begin
          want = pending_replies.pop_front();
          if (result.status !== want.status || result.slot_out !== want.slot_out ||
              result.active !== want.active || result.pos_x !== want.pos_x ||
              result.pos_y !== want.pos_y || result.damage !== want.damage ||
              result.player_count !== want.player_count ||
              result.enemy_count !== want.enemy_count) begin
            bad_words++;
            if (bad_words <= 10) begin
              $display({"mismatch cycle %0d exp: st=%0d slot=%0d act=%0d x=%0d y=%0d",
                        " dmg=%0d pc=%0d ec=%0d"},
                       cycles, want.status, want.slot_out, want.active, want.pos_x,
                       want.pos_y, want.damage, want.player_count, want.enemy_count);
              $display({"                 got: st=%0d slot=%0d act=%0d x=%0d y=%0d",
                        " dmg=%0d pc=%0d ec=%0d"},
                       result.status, result.slot_out, result.active, result.pos_x,
                       result.pos_y, result.damage, result.player_count, result.enemy_count);
            end
          end
        end
      end
      if (start && !busy) begin
        pool_step(item, pred);
        pending_replies.push_back(pred);
        taken_cnt++;
      end
    end
  end

  always @(posedge clk) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int n;
    int k;
    int scen;
    int r;
    logic p;
    for (k = 0; k < POOL_CAP; k++) begin
      pools[1][k] = '0;
      pools[0][k] = '0;
    end
    live_cnt[0] = '0;
    live_cnt[1] = '0;

    // empty engine: reads and destroys of unused and out-of-range slots, invalid-type spawn
    queue_word(mk(CMD_READ, 1'b1, TYPE_PLAYER, 0, 0, 0, 0, 0));
    queue_word(mk(CMD_READ, 1'b0, TYPE_INVALID, -1, -1, -1, -1, 63));
    queue_word(mk(CMD_DESTROY, 1'b1, TYPE_PLAYER, 0, 0, 0, 0, PLAYER_SLOTS));
    queue_word(mk(CMD_DESTROY, 1'b0, TYPE_PLAYER, 0, 0, 0, 0, ENEMY_SLOTS - 1));
    queue_word(mk(CMD_SPAWN, 1'b1, TYPE_INVALID, 5, 5, 1, 1, 0));
    // field extremes, boundary positions and all three kinds in both pools
    queue_word(mk(CMD_SPAWN, 1'b1, TYPE_PLAYER, -32768, 32767, 32767, -32768, 63));
    queue_word(mk(CMD_SPAWN, 1'b1, TYPE_MISSILE, -10, 330, 0, 0, 0));
    queue_word(mk(CMD_SPAWN, 1'b1, TYPE_ENEMY, 250, -10, 1, -1, 0));
    queue_word(mk(CMD_SPAWN, 1'b0, TYPE_ENEMY, 250, -10, 0, 0, 0));
    queue_word(mk(CMD_SPAWN, 1'b0, TYPE_MISSILE, 0, 0, -1, 1, 0));
    queue_word(mk(CMD_SPAWN, 1'b0, TYPE_PLAYER, 250, 330, 0, -1, 0));
    queue_word(mk(CMD_TICK, 1'b1, TYPE_INVALID, -1, -1, -1, -1, 63));
    for (k = 0; k < 3; k++) begin
      queue_word(mk(CMD_READ, 1'b1, TYPE_PLAYER, 0, 0, 0, 0, k));
      queue_word(mk(CMD_READ, 1'b0, TYPE_PLAYER, 0, 0, 0, 0, k));
    end
    queue_word(mk(CMD_DESTROY, 1'b1, TYPE_PLAYER, 0, 0, 0, 0, 1));
    queue_word(mk(CMD_DESTROY, 1'b1, TYPE_PLAYER, 0, 0, 0, 0, 1));
    queue_word(mk(CMD_READ, 1'b0, TYPE_PLAYER, 0, 0, 0, 0, ENEMY_SLOTS));
    queue_word(mk(CMD_READ, 1'b1, TYPE_PLAYER, 0, 0, 0, 0, PLAYER_SLOTS - 1));
    queue_word(mk(CMD_TICK, 1'b0, TYPE_PLAYER, 0, 0, 0, 0, 0));
    queue_word(mk(CMD_SPAWN, 1'b0, TYPE_INVALID, 0, 0, 0, 0, 0));

    n = 0;
    while (n < RANDOM_WORDS) begin
      scen = int'($urandom_range(0, 9));
      p = 1'($urandom_range(0, 1));
      if (scen < 2) begin
        // spawn burst, long enough to fill a pool now and then
        for (k = int'($urandom_range(4, 40)); k > 0; k--) begin
          queue_word(spawn_word(p, $urandom_range(0, 19) == 0));
          n++;
        end
      end else if (scen == 2) begin
        for (k = int'($urandom_range(1, 6)); k > 0; k--) begin
          queue_word(slot_word(CMD_TICK, 1'($urandom_range(0, 1)), 1'b1));
          n++;
        end
      end else if (scen == 8) begin
        for (k = int'($urandom_range(2, 10)); k > 0; k--) begin
          queue_word(slot_word(CMD_DESTROY, p, $urandom_range(0, 9) == 0));
          n++;
        end
      end else if (scen == 9) begin
        for (k = int'($urandom_range(2, 12)); k > 0; k--) begin
          queue_word(slot_word(CMD_READ, p, $urandom_range(0, 9) == 0));
          n++;
        end
      end else begin
        r = int'($urandom_range(0, 99));
        if (r < 30) queue_word(spawn_word(p, $urandom_range(0, 5) == 0));
        else if (r < 50) queue_word(slot_word(CMD_DESTROY, p, $urandom_range(0, 4) == 0));
        else if (r < 65) queue_word(slot_word(CMD_TICK, p, 1'b1));
        else queue_word(slot_word(CMD_READ, p, $urandom_range(0, 4) == 0));
        n++;
      end
    end
    total_words = cmd_backlog.size();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (taken_cnt < total_words) @(posedge clk);
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (bad_words == 0 && pending_replies.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
